>>> design/tgf_pkg.sv
// shared types and constants for the team grouped fifo
// no dependencies; used by team_grouped_fifo
`default_nettype none

package tgf_pkg;

  localparam int ELEMENT_IDS = 1024;
  localparam int TEAMS       = 1024;
  localparam int CAPACITY    = 1024;

  localparam int ELEM_W  = $clog2(ELEMENT_IDS);
  localparam int TEAM_W  = $clog2(TEAMS);
  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ORDER_W = $clog2(TEAMS + 1);

  localparam logic [CNT_W-1:0]  CAP_COUNT = CNT_W'(CAPACITY);
  localparam logic [TEAM_W-1:0] TEAM_LAST = TEAM_W'(TEAMS - 1);

  typedef enum logic [1:0] {
    FUNC_ASSIGN = 2'd0,
    FUNC_ENQ    = 2'd1,
    FUNC_DEQ    = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ENQ_MAP,
    ST_ENQ_TEAM,
    ST_DEQ_RING,
    ST_DEQ_TEAM,
    ST_DEQ_SLOT
  } state_t;

  typedef struct packed {
    logic              active;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
  } team_entry_t;

endpackage

`default_nettype wire

>>> design/tgf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/team_grouped_fifo.sv
// team grouped fifo top level: sequencer over map, team, ring and slot rams
// depends on tgf_pkg and tgf_ram
`default_nettype none

// One command is worked at a time; busy is high while it runs and done strobes
// its single result for one cycle, which the receiver must take. Assign and
// every error reply straight from idle; enqueue passes through map read, team
// entry read and link write, dequeue through ring read, team entry read, slot
// read and write back. Clear sweeps the team table one entry a cycle to drop
// every active flag, then replies. After reset the same sweep runs with busy
// high and no reply. The element to team map is kept across clear.
module team_grouped_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                func,
  input  wire logic [tgf_pkg::ELEM_W-1:0] element,
  input  wire logic [tgf_pkg::TEAM_W-1:0] team_id,
  output logic                           done,
  output logic [tgf_pkg::ELEM_W-1:0]      out_element,
  output logic [1:0]                     status
);

  localparam int ELEM_W  = tgf_pkg::ELEM_W;
  localparam int TEAM_W  = tgf_pkg::TEAM_W;
  localparam int SLOT_W  = tgf_pkg::SLOT_W;
  localparam int CNT_W   = tgf_pkg::CNT_W;
  localparam int ORDER_W = tgf_pkg::ORDER_W;
  localparam int ENT_W   = $bits(tgf_pkg::team_entry_t);

  tgf_pkg::state_t state, state_next;

  logic [TEAM_W-1:0]  sweep_addr, sweep_addr_next;
  logic               sweep_reply, sweep_reply_next;
  logic [TEAM_W-1:0]  order_head, order_head_next;
  logic [ORDER_W-1:0] order_count, order_count_next;
  logic [SLOT_W-1:0]  free_head, free_head_next;
  logic [CNT_W-1:0]   fresh_slots, fresh_slots_next;
  logic [CNT_W-1:0]   queued_count, queued_count_next;

  logic [ELEM_W-1:0]  elem_q, elem_q_next;
  logic [TEAM_W-1:0]  team_q, team_q_next;
  logic [SLOT_W-1:0]  slot_q, slot_q_next;
  tgf_pkg::team_entry_t ent_q, ent_q_next;

  logic               done_next;
  logic [ELEM_W-1:0]  out_next;
  logic [1:0]         status_next;

  // ram ports
  logic               map_we;
  logic [TEAM_W-1:0]  map_rdata;
  logic               team_we;
  logic [TEAM_W-1:0]  team_waddr, team_raddr;
  tgf_pkg::team_entry_t team_wdata, team_rd;
  logic [ENT_W-1:0]   team_rdata;
  logic               ring_we;
  logic [TEAM_W-1:0]  ring_waddr, ring_rdata;
  logic               val_we;
  logic [SLOT_W-1:0]  val_waddr, slot_raddr;
  logic [ELEM_W-1:0]  val_rdata;
  logic               nxt_we;
  logic [SLOT_W-1:0]  nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;

  logic               accept;
  logic [TEAM_W-1:0]  ring_tail;
  logic [SLOT_W-1:0]  alloc_slot;

  assign busy      = (state != tgf_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign team_rd   = tgf_pkg::team_entry_t'(team_rdata);
  assign ring_tail = order_head + order_count[TEAM_W-1:0];

  tgf_ram #(.WIDTH(TEAM_W), .DEPTH(tgf_pkg::ELEMENT_IDS)) u_map_ram (
    .clk(clk), .we(map_we), .waddr(element), .wdata(team_id),
    .raddr(element), .rdata(map_rdata)
  );

  tgf_ram #(.WIDTH(ENT_W), .DEPTH(tgf_pkg::TEAMS)) u_team_ram (
    .clk(clk), .we(team_we), .waddr(team_waddr), .wdata(team_wdata),
    .raddr(team_raddr), .rdata(team_rdata)
  );

  tgf_ram #(.WIDTH(TEAM_W), .DEPTH(tgf_pkg::TEAMS)) u_ring_ram (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(team_q),
    .raddr(order_head), .rdata(ring_rdata)
  );

  tgf_ram #(.WIDTH(ELEM_W), .DEPTH(tgf_pkg::CAPACITY)) u_value_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(elem_q),
    .raddr(slot_raddr), .rdata(val_rdata)
  );

  tgf_ram #(.WIDTH(SLOT_W), .DEPTH(tgf_pkg::CAPACITY)) u_link_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(nxt_raddr), .rdata(nxt_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tgf_pkg::ST_SWEEP: begin
        if (sweep_addr == tgf_pkg::TEAM_LAST) state_next = tgf_pkg::ST_IDLE;
      end
      tgf_pkg::ST_IDLE: begin
        if (start) begin
          unique case (func)
            tgf_pkg::FUNC_ASSIGN: state_next = tgf_pkg::ST_IDLE;
            tgf_pkg::FUNC_ENQ: begin
              if (queued_count != tgf_pkg::CAP_COUNT) state_next = tgf_pkg::ST_ENQ_MAP;
            end
            tgf_pkg::FUNC_DEQ: begin
              if (order_count != '0) state_next = tgf_pkg::ST_DEQ_RING;
            end
            tgf_pkg::FUNC_CLEAR: state_next = tgf_pkg::ST_SWEEP;
            default: state_next = tgf_pkg::ST_IDLE;
          endcase
        end
      end
      tgf_pkg::ST_ENQ_MAP:  state_next = tgf_pkg::ST_ENQ_TEAM;
      tgf_pkg::ST_ENQ_TEAM: state_next = tgf_pkg::ST_IDLE;
      tgf_pkg::ST_DEQ_RING: state_next = tgf_pkg::ST_DEQ_TEAM;
      tgf_pkg::ST_DEQ_TEAM: state_next = tgf_pkg::ST_DEQ_SLOT;
      tgf_pkg::ST_DEQ_SLOT: state_next = tgf_pkg::ST_IDLE;
      default:              state_next = tgf_pkg::ST_IDLE;
    endcase
  end

  // slot for an enqueue: untouched slots in order first, then the free list
  always_comb begin
    if (fresh_slots != '0) begin
      alloc_slot = SLOT_W'(tgf_pkg::CAP_COUNT - fresh_slots);
    end else begin
      alloc_slot = free_head;
    end
  end

  // ram controls, counters and reply
  always_comb begin
    sweep_addr_next   = sweep_addr;
    sweep_reply_next  = sweep_reply;
    order_head_next   = order_head;
    order_count_next  = order_count;
    free_head_next    = free_head;
    fresh_slots_next  = fresh_slots;
    queued_count_next = queued_count;
    elem_q_next       = elem_q;
    team_q_next       = team_q;
    slot_q_next       = slot_q;
    ent_q_next        = ent_q;
    done_next         = 1'b0;
    out_next          = '0;
    status_next       = tgf_pkg::STATUS_OK;

    map_we     = 1'b0;
    team_we    = 1'b0;
    team_waddr = team_q;
    team_wdata = '0;
    team_raddr = (state == tgf_pkg::ST_ENQ_MAP) ? map_rdata : ring_rdata;
    ring_we    = 1'b0;
    ring_waddr = ring_tail;
    val_we     = 1'b0;
    val_waddr  = alloc_slot;
    slot_raddr = team_rd.head;
    nxt_we     = 1'b0;
    nxt_waddr  = ent_q.head;
    nxt_wdata  = free_head;
    nxt_raddr  = (state == tgf_pkg::ST_IDLE) ? free_head : team_rd.head;

    unique case (state)
      tgf_pkg::ST_SWEEP: begin
        team_we         = 1'b1;
        team_waddr      = sweep_addr;
        team_wdata      = '0;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == tgf_pkg::TEAM_LAST) begin
          done_next        = sweep_reply;
          sweep_reply_next = 1'b0;
        end
      end
      tgf_pkg::ST_IDLE: begin
        elem_q_next = element;
        if (start) begin
          unique case (func)
            tgf_pkg::FUNC_ASSIGN: begin
              map_we    = 1'b1;
              done_next = 1'b1;
            end
            tgf_pkg::FUNC_ENQ: begin
              if (queued_count == tgf_pkg::CAP_COUNT) begin
                done_next   = 1'b1;
                status_next = tgf_pkg::STATUS_FULL;
              end
            end
            tgf_pkg::FUNC_DEQ: begin
              if (order_count == '0) begin
                done_next   = 1'b1;
                status_next = tgf_pkg::STATUS_EMPTY;
              end
            end
            tgf_pkg::FUNC_CLEAR: begin
              sweep_addr_next   = '0;
              sweep_reply_next  = 1'b1;
              order_head_next   = '0;
              order_count_next  = '0;
              free_head_next    = '0;
              fresh_slots_next  = tgf_pkg::CAP_COUNT;
              queued_count_next = '0;
            end
            default: begin
              done_next = 1'b0;
            end
          endcase
        end
      end
      tgf_pkg::ST_ENQ_MAP: begin
        team_q_next = map_rdata;
        slot_q_next = alloc_slot;
        val_we      = 1'b1;
        if (fresh_slots != '0) begin
          fresh_slots_next = fresh_slots - 1'b1;
        end else begin
          free_head_next = nxt_rdata;
        end
      end
      tgf_pkg::ST_ENQ_TEAM: begin
        team_we = 1'b1;
        if (team_rd.active) begin
          // append to the tail of the team's group
          nxt_we     = 1'b1;
          nxt_waddr  = team_rd.tail;
          nxt_wdata  = slot_q;
          team_wdata = '{active: 1'b1, head: team_rd.head, tail: slot_q};
        end else begin
          team_wdata       = '{active: 1'b1, head: slot_q, tail: slot_q};
          ring_we          = 1'b1;
          order_count_next = order_count + 1'b1;
        end
        queued_count_next = queued_count + 1'b1;
        done_next         = 1'b1;
      end
      tgf_pkg::ST_DEQ_RING: begin
        team_q_next = ring_rdata;
      end
      tgf_pkg::ST_DEQ_TEAM: begin
        ent_q_next = team_rd;
      end
      tgf_pkg::ST_DEQ_SLOT: begin
        team_we = 1'b1;
        if (ent_q.head == ent_q.tail) begin
          // group empties, front team leaves the ring
          team_wdata       = '{active: 1'b0, head: ent_q.head, tail: ent_q.tail};
          order_head_next  = order_head + 1'b1;
          order_count_next = order_count - 1'b1;
        end else begin
          team_wdata = '{active: 1'b1, head: nxt_rdata, tail: ent_q.tail};
        end
        nxt_we            = 1'b1;
        nxt_waddr         = ent_q.head;
        nxt_wdata         = free_head;
        free_head_next    = ent_q.head;
        queued_count_next = queued_count - 1'b1;
        done_next         = 1'b1;
        out_next          = val_rdata;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tgf_pkg::ST_SWEEP;
      sweep_addr   <= '0;
      sweep_reply  <= 1'b0;
      order_head   <= '0;
      order_count  <= '0;
      free_head    <= '0;
      fresh_slots  <= tgf_pkg::CAP_COUNT;
      queued_count <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      sweep_addr   <= sweep_addr_next;
      sweep_reply  <= sweep_reply_next;
      order_head   <= order_head_next;
      order_count  <= order_count_next;
      free_head    <= free_head_next;
      fresh_slots  <= fresh_slots_next;
      queued_count <= queued_count_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    elem_q      <= elem_q_next;
    team_q      <= team_q_next;
    slot_q      <= slot_q_next;
    ent_q       <= ent_q_next;
    out_element <= out_next;
    status      <= status_next;
  end

  // no active team without a queued element and the other way round
  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (queued_count == '0) == (order_count == '0))
    else $error("team ring and element count disagree on empty");

  // slots never handed out plus queued elements never exceed the buffer
  a_slot_budget: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, fresh_slots} + {1'b0, queued_count}) <= {1'b0, tgf_pkg::CAP_COUNT})
    else $error("slot accounting overflow");

  a_deq_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && func == tgf_pkg::FUNC_DEQ && order_count == '0)
      |=> (done && status == tgf_pkg::STATUS_EMPTY))
    else $error("dequeue on empty not reported at once");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != tgf_pkg::STATUS_OK) |-> (out_element == '0))
    else $error("error reply carries an element");

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    order_count <= ORDER_W'(tgf_pkg::TEAMS))
    else $error("more active teams than ring entries");

endmodule

`default_nettype wire
